/* hdl/efu_pkg.sv */
// shared types, codes and defaults for the task event flag unit
`default_nettype none

package efu_pkg;

  // default sizes
  localparam int TASK_SLOTS_DEF = 8;
  localparam int FLAG_BITS_DEF  = 32;

  // fixed port widths
  localparam int FUNC_W = 3;
  localparam int TASK_W = 3;
  localparam int MASK_W = 32;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_SEND      = 3'd0,
    FN_RECEIVE   = 3'd1,
    FN_FETCH     = 3'd2,
    FN_CLEAR     = 3'd3,
    FN_COLLECT   = 3'd4,
    FN_TIMEOUT   = 3'd5,
    FN_TERMINATE = 3'd6
  } func_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_EVENTS = 3'd1,
    ST_UNAVAIL   = 3'd2,
    ST_PENDING   = 3'd3,
    ST_TIMED_OUT = 3'd4,
    ST_DELETED   = 3'd5
  } status_t;

  // wait modes of a receive
  typedef struct packed {
    logic keep_unwanted;
    logic return_all;
    logic wait_all;
  } mode_t;

  // per-slot control bits
  typedef struct packed {
    mode_t modes;
    logic  waiting;
    logic  deleted;
  } slot_ctl_t;

endpackage

`default_nettype wire

/* hdl/efu_slot_store.sv */
// per-slot flag table: received flags, wanted flags and control bits
`default_nettype none

module efu_slot_store
  import efu_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF,
  parameter int FLAG_BITS  = FLAG_BITS_DEF,
  parameter int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [SLOT_W-1:0]    rd_idx,
  output logic      [FLAG_BITS-1:0] rd_recv,
  output logic      [FLAG_BITS-1:0] rd_want,
  output slot_ctl_t                 rd_ctl,
  input  wire logic                 wr_en,
  input  wire logic [SLOT_W-1:0]    wr_idx,
  input  wire logic [FLAG_BITS-1:0] wr_recv,
  input  wire logic [FLAG_BITS-1:0] wr_want,
  input  slot_ctl_t                 wr_ctl
);

  logic [FLAG_BITS-1:0] recv [TASK_SLOTS];
  logic [FLAG_BITS-1:0] want [TASK_SLOTS];
  slot_ctl_t            ctl  [TASK_SLOTS];

  // table update, cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        recv[i] <= '0;
        want[i] <= '0;
        ctl[i]  <= '0;
      end
    end else if (wr_en) begin
      recv[wr_idx] <= wr_recv;
      want[wr_idx] <= wr_want;
      ctl[wr_idx]  <= wr_ctl;
    end
  end

  // read of the slot under work
  assign rd_recv = recv[rd_idx];
  assign rd_want = want[rd_idx];
  assign rd_ctl  = ctl[rd_idx];

endmodule

`default_nettype wire

/* hdl/efu_op_logic.sv */
// operation decode: next slot entry and result for one request
`default_nettype none

module efu_op_logic
  import efu_pkg::*;
#(
  parameter int FLAG_BITS = FLAG_BITS_DEF
) (
  input  func_t                     func,
  input  wire logic [FLAG_BITS-1:0] mask,
  input  mode_t                     modes,
  input  wire logic                 no_wait,
  input  wire logic [FLAG_BITS-1:0] cur_recv,
  input  wire logic [FLAG_BITS-1:0] cur_want,
  input  slot_ctl_t                 cur_ctl,
  output logic      [FLAG_BITS-1:0] nxt_recv,
  output logic      [FLAG_BITS-1:0] nxt_want,
  output slot_ctl_t                 nxt_ctl,
  output status_t                   res_status,
  output logic      [FLAG_BITS-1:0] res_events,
  output logic                      res_wake
);

  logic [FLAG_BITS-1:0] sent_recv;
  logic [FLAG_BITS-1:0] want_hit;
  logic                 send_met;
  logic [FLAG_BITS-1:0] rx_hit;
  logic                 rx_sat;
  logic [FLAG_BITS-1:0] tk_mask;
  mode_t                tk_modes;
  logic                 tk_all_ok;
  logic [FLAG_BITS-1:0] tk_back;
  logic [FLAG_BITS-1:0] tk_left;

  // wait check after a send
  assign sent_recv = cur_recv | mask;
  assign want_hit  = cur_want & sent_recv;
  assign send_met  = (want_hit == cur_want) ||
                     (!cur_ctl.modes.wait_all && (want_hit != '0));

  // receive match in any or all mode
  assign rx_hit = mask & cur_recv;
  assign rx_sat = modes.wait_all ? (rx_hit == mask) : (rx_hit != '0);

  // shared hand-back and clear; receive uses the request, others the stored wait
  always_comb begin
    if (func == FN_RECEIVE) begin
      tk_mask   = mask;
      tk_modes  = modes;
      tk_all_ok = rx_sat && modes.wait_all;
    end else begin
      tk_mask   = cur_want;
      tk_modes  = cur_ctl.modes;
      tk_all_ok = 1'b0;
    end
  end

  always_comb begin
    if (tk_modes.return_all) begin
      tk_back = cur_recv;
    end else if (tk_all_ok) begin
      tk_back = tk_mask;
    end else begin
      tk_back = tk_mask & cur_recv;
    end
    if (tk_modes.keep_unwanted && !tk_modes.return_all) begin
      tk_left = cur_recv & ~tk_mask;
    end else begin
      tk_left = '0;
    end
  end

  // per-operation next state and result
  always_comb begin
    nxt_recv   = cur_recv;
    nxt_want   = cur_want;
    nxt_ctl    = cur_ctl;
    res_status = ST_OK;
    res_events = '0;
    res_wake   = 1'b0;
    case (func)
      FN_SEND: begin
        nxt_recv = sent_recv;
        if (cur_ctl.waiting && send_met) begin
          nxt_ctl.waiting = 1'b0;
          res_wake        = 1'b1;
        end
      end
      FN_RECEIVE: begin
        if (mask == '0) begin
          res_status = ST_NO_EVENTS;
        end else if (rx_sat) begin
          res_events = tk_back;
          nxt_recv   = tk_left;
        end else if (no_wait) begin
          res_events = tk_back;
          nxt_recv   = tk_left;
          res_status = ST_UNAVAIL;
        end else begin
          nxt_want        = mask;
          nxt_ctl.modes   = modes;
          nxt_ctl.waiting = 1'b1;
          nxt_ctl.deleted = 1'b0;
          res_status      = ST_PENDING;
        end
      end
      FN_FETCH: begin
        res_events = cur_recv;
      end
      FN_CLEAR: begin
        nxt_recv = '0;
      end
      FN_COLLECT: begin
        if (cur_ctl.waiting) begin
          res_status = ST_PENDING;
        end else begin
          res_events = tk_back;
          nxt_recv   = tk_left;
          if (cur_ctl.deleted) begin
            nxt_ctl.deleted = 1'b0;
            res_status      = ST_DELETED;
          end
        end
      end
      FN_TIMEOUT: begin
        if (cur_ctl.waiting) begin
          nxt_ctl.waiting = 1'b0;
          res_events      = tk_back;
          nxt_recv        = tk_left;
          res_status      = ST_TIMED_OUT;
        end
      end
      FN_TERMINATE: begin
        if (cur_ctl.waiting) begin
          nxt_ctl.waiting = 1'b0;
          nxt_ctl.deleted = 1'b1;
          res_wake        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/task_event_flag_unit_top.sv */
// top level of the task event flag unit: request register, slot table, result register
`default_nettype none

// Event flag unit for up to TASK_SLOTS task slots with FLAG_BITS flags each. Every
// request (send, receive, fetch, clear, collect, timeout, terminate) gives exactly
// one result. A request is registered on acceptance; from the request register the
// slot table entry is read, updated and written back while the result is loaded
// into the output register. One request is taken every cycle while the output is
// not stalled, and the read-modify-write of the slot table for each request lets
// back-to-back requests on the same slot see each other's updates. Requests
// naming a slot at or above TASK_SLOTS, and the unused operation code, return an
// all-zero result and change nothing.
module task_event_flag_unit_top
  import efu_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF,
  parameter int FLAG_BITS  = FLAG_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [FUNC_W-1:0] func,
  input  wire logic [TASK_W-1:0] task_req,
  input  wire logic [MASK_W-1:0] event_mask,
  input  wire logic              wait_all,
  input  wire logic              return_all,
  input  wire logic              keep_unwanted,
  input  wire logic              no_wait,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             status,
  output logic [MASK_W-1:0]      events_out,
  output logic                   wake,
  output logic [TASK_W-1:0]      wake_task
);

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  // request register
  logic                 req_valid;
  func_t                req_func;
  logic [TASK_W-1:0]    req_task;
  logic [FLAG_BITS-1:0] req_mask;
  mode_t                req_modes;
  logic                 req_no_wait;

  // pipeline control
  logic advance;
  logic fire;
  logic slot_ok;
  logic [SLOT_W-1:0] slot_idx;

  // table read and update
  logic [FLAG_BITS-1:0] cur_recv;
  logic [FLAG_BITS-1:0] cur_want;
  slot_ctl_t            cur_ctl;
  logic [FLAG_BITS-1:0] nxt_recv;
  logic [FLAG_BITS-1:0] nxt_want;
  slot_ctl_t            nxt_ctl;
  status_t              res_status;
  logic [FLAG_BITS-1:0] res_events;
  logic                 res_wake;

  assign advance  = !out_valid || !out_stall;
  assign fire     = req_valid && advance;
  assign in_stall = req_valid && !advance;

  assign slot_ok  = (32'(req_task) < 32'(TASK_SLOTS));
  assign slot_idx = SLOT_W'(req_task);

  // capture request
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_func    <= func_t'(func);
      req_task    <= task_req;
      req_mask    <= FLAG_BITS'(event_mask);
      req_modes   <= '{keep_unwanted: keep_unwanted, return_all: return_all,
                       wait_all: wait_all};
      req_no_wait <= no_wait;
    end
  end

  // slot table
  efu_slot_store #(
    .TASK_SLOTS (TASK_SLOTS),
    .FLAG_BITS  (FLAG_BITS),
    .SLOT_W     (SLOT_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_idx  (slot_idx),
    .rd_recv (cur_recv),
    .rd_want (cur_want),
    .rd_ctl  (cur_ctl),
    .wr_en   (fire && slot_ok),
    .wr_idx  (slot_idx),
    .wr_recv (nxt_recv),
    .wr_want (nxt_want),
    .wr_ctl  (nxt_ctl)
  );

  // operation logic
  efu_op_logic #(
    .FLAG_BITS (FLAG_BITS)
  ) u_op (
    .func       (req_func),
    .mask       (req_mask),
    .modes      (req_modes),
    .no_wait    (req_no_wait),
    .cur_recv   (cur_recv),
    .cur_want   (cur_want),
    .cur_ctl    (cur_ctl),
    .nxt_recv   (nxt_recv),
    .nxt_want   (nxt_want),
    .nxt_ctl    (nxt_ctl),
    .res_status (res_status),
    .res_events (res_events),
    .res_wake   (res_wake)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (slot_ok) begin
        status     <= res_status;
        events_out <= MASK_W'(res_events);
        wake       <= res_wake;
        wake_task  <= res_wake ? req_task : '0;
      end else begin
        status     <= ST_OK;
        events_out <= '0;
        wake       <= 1'b0;
        wake_task  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

/* verif/task_event_flag_unit_top_tb.sv */
// self-checking testbench for the task event flag unit: directed table, random sequences
module task_event_flag_unit_top_tb;
  import efu_pkg::*;

  localparam int SLOTS = TASK_SLOTS_DEF;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_PER_PHASE = 300;
  localparam int DRAIN_CYCLES = 8;

  // the operation code left undefined by the block
  localparam logic [FUNC_W-1:0] FN_RESERVED = 3'd7;

  // receive mode combinations used in the directed table
  localparam mode_t M_ANY      = 3'b000;
  localparam mode_t M_ALL      = 3'b001;
  localparam mode_t M_RETALL   = 3'b010;
  localparam mode_t M_ALL_KEEP = 3'b101;
  localparam mode_t M_EVERY    = 3'b111;

  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic [TASK_W-1:0] slot;
    logic [MASK_W-1:0] mask;
    mode_t             modes;
    logic              no_wait;
  } flag_request_t;

  typedef struct packed {
    status_t           status;
    logic [MASK_W-1:0] events;
    logic              wake;
    logic [TASK_W-1:0] wake_task;
  } flag_result_t;

  typedef struct {
    flag_request_t req;
    bit            typed;
    flag_result_t  result;
  } directed_row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [FUNC_W-1:0] func;
  logic [TASK_W-1:0] task_req;
  logic [MASK_W-1:0] event_mask;
  logic              wait_all;
  logic              return_all;
  logic              keep_unwanted;
  logic              no_wait;
  logic              out_valid;
  logic              out_stall;
  logic [2:0]        status;
  logic [MASK_W-1:0] events_out;
  logic              wake;
  logic [TASK_W-1:0] wake_task;

  task_event_flag_unit_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .task_req      (task_req),
    .event_mask    (event_mask),
    .wait_all      (wait_all),
    .return_all    (return_all),
    .keep_unwanted (keep_unwanted),
    .no_wait       (no_wait),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .events_out    (events_out),
    .wake          (wake),
    .wake_task     (wake_task)
  );

  // shadow copy of the slot table
  logic [MASK_W-1:0] rcvd_flags  [SLOTS];
  logic [MASK_W-1:0] want_flags  [SLOTS];
  mode_t             want_modes  [SLOTS];
  logic              task_waits  [SLOTS];
  logic              res_deleted [SLOTS];

  flag_result_t  owed_results [$];
  directed_row_t directed_rows [$];
  int unsigned   mismatch_count;
  int unsigned   requests_sent;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  int unsigned   flag_lane;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // hand flags back for a slot, then clear them as the modes say
  function automatic logic [MASK_W-1:0] take_flags(input logic [TASK_W-1:0] t,
                                                   input logic [MASK_W-1:0] m,
                                                   input mode_t md, input logic all_ok);
    logic [MASK_W-1:0] r;
    logic [MASK_W-1:0] back;
    r = rcvd_flags[t];
    if (md.return_all) back = r;
    else if (all_ok) back = m;
    else back = m & r;
    if (md.keep_unwanted && !md.return_all) rcvd_flags[t] = r & ~m;
    else rcvd_flags[t] = '0;
    return back;
  endfunction

  // expected result of one request, updating the shadow table
  function automatic flag_result_t predict_flag_op(input flag_request_t req);
    flag_result_t      res;
    logic [TASK_W-1:0] t;
    logic [MASK_W-1:0] hit;
    logic              met;
    t = req.slot;
    res = '{ST_OK, '0, 1'b0, '0};
    case (req.op)
      FN_SEND: begin
        rcvd_flags[t] = rcvd_flags[t] | req.mask;
        hit = want_flags[t] & rcvd_flags[t];
        met = (hit == want_flags[t]) || (!want_modes[t].wait_all && hit != '0);
        if (task_waits[t] && met) begin
          task_waits[t] = 1'b0;
          res.wake = 1'b1;
          res.wake_task = t;
        end
      end
      FN_RECEIVE: begin
        hit = req.mask & rcvd_flags[t];
        if (req.mask == '0) begin
          res.status = ST_NO_EVENTS;
        end else if (req.modes.wait_all ? hit == req.mask : hit != '0) begin
          res.events = take_flags(t, req.mask, req.modes, req.modes.wait_all);
        end else if (req.no_wait) begin
          res.events = take_flags(t, req.mask, req.modes, 1'b0);
          res.status = ST_UNAVAIL;
        end else begin
          want_flags[t] = req.mask;
          want_modes[t] = req.modes;
          task_waits[t] = 1'b1;
          res_deleted[t] = 1'b0;
          res.status = ST_PENDING;
        end
      end
      FN_FETCH: res.events = rcvd_flags[t];
      FN_CLEAR: rcvd_flags[t] = '0;
      FN_COLLECT: begin
        if (task_waits[t]) begin
          res.status = ST_PENDING;
        end else begin
          res.events = take_flags(t, want_flags[t], want_modes[t], 1'b0);
          if (res_deleted[t]) begin
            res_deleted[t] = 1'b0;
            res.status = ST_DELETED;
          end
        end
      end
      FN_TIMEOUT: begin
        if (task_waits[t]) begin
          task_waits[t] = 1'b0;
          res.events = take_flags(t, want_flags[t], want_modes[t], 1'b0);
          res.status = ST_TIMED_OUT;
        end
      end
      FN_TERMINATE: begin
        if (task_waits[t]) begin
          task_waits[t] = 1'b0;
          res_deleted[t] = 1'b1;
          res.wake = 1'b1;
          res.wake_task = t;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic flag_request_t mk_req(input logic [FUNC_W-1:0] op,
                                           input logic [TASK_W-1:0] slot,
                                           input logic [MASK_W-1:0] mask,
                                           input mode_t modes, input logic nw);
    flag_request_t req;
    req.op = op;
    req.slot = slot;
    req.mask = mask;
    req.modes = modes;
    req.no_wait = nw;
    return req;
  endfunction

  function automatic void add_row(input logic [FUNC_W-1:0] op, input logic [TASK_W-1:0] slot,
                                  input logic [MASK_W-1:0] mask, input mode_t modes,
                                  input logic nw, input bit typed, input status_t st,
                                  input logic [MASK_W-1:0] ev, input logic wk,
                                  input logic [TASK_W-1:0] wt);
    directed_row_t row;
    row.req = mk_req(op, slot, mask, modes, nw);
    row.typed = typed;
    row.result = '{st, ev, wk, wt};
    directed_rows.push_back(row);
  endfunction

  // present one request, hold it until taken, then log what it should give
  task automatic drive_request(input flag_request_t req, input bit typed,
                               input flag_result_t typed_res);
    flag_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    func          <= req.op;
    task_req      <= req.slot;
    event_mask    <= req.mask;
    wait_all      <= req.modes.wait_all;
    return_all    <= req.modes.return_all;
    keep_unwanted <= req.modes.keep_unwanted;
    no_wait       <= req.no_wait;
    do @(posedge clk); while (in_stall);
    predicted = predict_flag_op(req);
    owed_results.push_back(typed ? typed_res : predicted);
    requests_sent++;
    @(negedge clk);
  endtask

  // mostly a few flags in one nibble lane so that waits get satisfied
  function automatic logic [MASK_W-1:0] rand_mask();
    case ($urandom_range(0, 15))
      0: return $urandom;
      1: return '0;
      2: return '1;
      default: return MASK_W'($urandom_range(1, 15)) << (4 * flag_lane);
    endcase
  endfunction

  // one random call pattern on a slot, or a stray request
  task automatic run_sequence();
    logic [TASK_W-1:0] t;
    logic [MASK_W-1:0] m;
    mode_t             md;
    flag_result_t      none;
    none = '{ST_OK, '0, 1'b0, '0};
    if ($urandom_range(0, 7) == 0) flag_lane = $urandom_range(0, 7);
    t = TASK_W'($urandom_range(0, SLOTS - 1));
    m = rand_mask();
    md = mode_t'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0, 1: begin
        drive_request(mk_req(FUNC_W'($urandom_range(0, 7)), t, $urandom,
                             mode_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1))),
                      1'b0, none);
      end
      2: begin
        drive_request(mk_req(FN_SEND, t, rand_mask(), M_ANY, 1'b0), 1'b0, none);
        drive_request(mk_req(FN_RECEIVE, t, m, md, 1'($urandom_range(0, 1))), 1'b0, none);
      end
      3: begin
        drive_request(mk_req($urandom_range(0, 1) ? FN_FETCH : FN_CLEAR, t, $urandom, md,
                             1'($urandom_range(0, 1))), 1'b0, none);
      end
      4, 5, 6: begin
        // wait, a few sends, then collect
        drive_request(mk_req(FN_RECEIVE, t, m, md, 1'b0), 1'b0, none);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 3) == 0)
            drive_request(mk_req(FN_COLLECT, t, $urandom, md, 1'b0), 1'b0, none);
          drive_request(mk_req(FN_SEND, t, $urandom_range(0, 2) != 0 ? (m & $urandom) :
                               rand_mask(), M_ANY, 1'b0), 1'b0, none);
        end
        drive_request(mk_req(FN_COLLECT, t, $urandom, md, 1'b0), 1'b0, none);
      end
      7: begin
        drive_request(mk_req(FN_RECEIVE, t, m, md, 1'b0), 1'b0, none);
        if ($urandom_range(0, 1))
          drive_request(mk_req(FN_SEND, t, rand_mask(), M_ANY, 1'b0), 1'b0, none);
        drive_request(mk_req(FN_TIMEOUT, t, $urandom, md, 1'b0), 1'b0, none);
        drive_request(mk_req(FN_COLLECT, t, $urandom, md, 1'b0), 1'b0, none);
      end
      8: begin
        drive_request(mk_req(FN_RECEIVE, t, m, md, 1'b0), 1'b0, none);
        drive_request(mk_req(FN_TERMINATE, t, $urandom, md, 1'b0), 1'b0, none);
        if ($urandom_range(0, 1))
          drive_request(mk_req(FN_SEND, t, rand_mask(), M_ANY, 1'b0), 1'b0, none);
        drive_request(mk_req(FN_COLLECT, t, $urandom, md, 1'b0), 1'b0, none);
      end
      default: begin
        // send lands on another slot, the wait times out
        drive_request(mk_req(FN_RECEIVE, t, m, md, 1'b0), 1'b0, none);
        drive_request(mk_req(FN_SEND, t + 3'd1, m, M_ANY, 1'b0), 1'b0, none);
        drive_request(mk_req(FN_TIMEOUT, t, $urandom, md, 1'b0), 1'b0, none);
      end
    endcase
  endtask

  // receiver stalls at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // compare each taken result with the oldest owed one
  always @(posedge clk) begin : result_check
    flag_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        report_mismatch("result with no request owed");
      end else begin
        want = owed_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (events_out !== want.events)
          report_mismatch($sformatf("events_out %h, want %h", events_out, want.events));
        if (wake !== want.wake)
          report_mismatch($sformatf("wake %b, want %b", wake, want.wake));
        if (wake_task !== want.wake_task)
          report_mismatch($sformatf("wake_task %0d, want %0d", wake_task, want.wake_task));
      end
    end
  end

  // hard limit on run length
  initial begin
    #2000000;
    $display("task_event_flag_unit_top_tb: FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    func = '0;
    task_req = '0;
    event_mask = '0;
    wait_all = 1'b0;
    return_all = 1'b0;
    keep_unwanted = 1'b0;
    no_wait = 1'b0;
    out_stall = 1'b0;
    mismatch_count = 0;
    requests_sent = 0;
    flag_lane = 0;
    send_idle_pct = 32;
    recv_idle_pct = 47;
    for (int i = 0; i < SLOTS; i++) begin
      rcvd_flags[i] = '0;
      want_flags[i] = '0;
      want_modes[i] = M_ANY;
      task_waits[i] = 1'b0;
      res_deleted[i] = 1'b0;
    end

    // directed table: typed results where obvious, the rest predicted
    add_row(FN_FETCH,     3'd0, 32'h0000_0000, M_ANY,      1'b0, 1, ST_OK,        '0, 0, 0);
    add_row(FN_RECEIVE,   3'd1, 32'h0000_0000, M_ALL,      1'b0, 1, ST_NO_EVENTS, '0, 0, 0);
    add_row(FN_RECEIVE,   3'd2, 32'hFFFF_FFFF, M_ANY,      1'b1, 1, ST_UNAVAIL,   '0, 0, 0);
    add_row(FN_SEND,      3'd3, 32'hFFFF_FFFF, M_ANY,      1'b0, 1, ST_OK,        '0, 0, 0);
    add_row(FN_FETCH,     3'd3, 32'h0000_0000, M_ANY,      1'b0, 1, ST_OK,        '1, 0, 0);
    add_row(FN_RECEIVE,   3'd3, 32'h0000_00F0, M_ALL_KEEP, 1'b0, 0, ST_OK,        '0, 0, 0);
    add_row(FN_FETCH,     3'd3, 32'h0000_0000, M_ANY,      1'b0, 0, ST_OK,        '0, 0, 0);
    add_row(FN_RECEIVE,   3'd3, 32'h8000_0000, M_RETALL,   1'b0, 0, ST_OK,        '0, 0, 0);
    add_row(FN_RECEIVE,   3'd3, 32'h0000_0001, M_ANY,      1'b1, 1, ST_UNAVAIL,   '0, 0, 0);
    add_row(FN_RECEIVE,   3'd4, 32'h0000_0005, M_ALL,      1'b0, 1, ST_PENDING,   '0, 0, 0);
    add_row(FN_COLLECT,   3'd4, 32'h0000_0000, M_ANY,      1'b0, 1, ST_PENDING,   '0, 0, 0);
    add_row(FN_SEND,      3'd4, 32'h0000_0001, M_ANY,      1'b0, 0, ST_OK,        '0, 0, 0);
    add_row(FN_SEND,      3'd4, 32'h0000_0004, M_ANY,      1'b0, 1, ST_OK,        '0, 1, 4);
    add_row(FN_COLLECT,   3'd4, 32'h0000_0000, M_ANY,      1'b0, 0, ST_OK,        '0, 0, 0);
    add_row(FN_RECEIVE,   3'd5, 32'h8000_0000, M_ANY,      1'b0, 1, ST_PENDING,   '0, 0, 0);
    add_row(FN_TIMEOUT,   3'd5, 32'h0000_0000, M_ANY,      1'b0, 1, ST_TIMED_OUT, '0, 0, 0);
    add_row(FN_TIMEOUT,   3'd5, 32'h0000_0000, M_ANY,      1'b0, 1, ST_OK,        '0, 0, 0);
    add_row(FN_RECEIVE,   3'd6, 32'h0000_0003, M_ANY,      1'b0, 1, ST_PENDING,   '0, 0, 0);
    add_row(FN_TERMINATE, 3'd6, 32'h0000_0000, M_ANY,      1'b0, 1, ST_OK,        '0, 1, 6);
    add_row(FN_COLLECT,   3'd6, 32'h0000_0000, M_ANY,      1'b0, 1, ST_DELETED,   '0, 0, 0);
    add_row(FN_TERMINATE, 3'd7, 32'h0000_0000, M_ANY,      1'b0, 1, ST_OK,        '0, 0, 0);
    add_row(FN_RESERVED,  3'd0, 32'hFFFF_FFFF, M_EVERY,    1'b1, 1, ST_OK,        '0, 0, 0);
    add_row(FN_SEND,      3'd7, 32'h0000_0001, M_ANY,      1'b0, 1, ST_OK,        '0, 0, 0);
    add_row(FN_RECEIVE,   3'd7, 32'h0000_0003, M_ALL_KEEP, 1'b1, 0, ST_OK,        '0, 0, 0);
    add_row(FN_CLEAR,     3'd7, 32'h0000_0000, M_ANY,      1'b0, 1, ST_OK,        '0, 0, 0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      drive_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].result);

    // random part: receiver-heavy idling, then sender-heavy, then none
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (requests_sent < DIRECTED_ROWS + (ph + 1) * RANDOM_PER_PHASE)
        run_sequence();
    end
    in_valid <= 1'b0;

    // drain
    while (owed_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("task_event_flag_unit_top_tb: PASS");
    end else begin
      $display("task_event_flag_unit_top_tb: FAIL");
    end
    $finish;
  end

endmodule
